>>> rtl/gregorian_date_day_adder_unit_macros.svh
// Assertion helpers shared by the date adder RTL.
`ifndef GREGORIAN_DATE_DAY_ADDER_UNIT_MACROS_SVH
`define GREGORIAN_DATE_DAY_ADDER_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define GDDA_CHECK_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define GDDA_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/gdda_pkg.sv
package gdda_pkg;

    // Year field width; the load-time reciprocal below is sized for it.
    localparam int YEAR_BITS   = 16;
    localparam int DAY_CNT_W   = 17;
    localparam int ADD_W       = 16;
    localparam int YR400_W     = 9;
    localparam int QUOT_W      = 8;
    localparam int RECIP_W     = 17;
    localparam int RECIP_SHIFT = 25;
    localparam int PC_W        = 3;

    typedef logic [YEAR_BITS-1:0] year_t;
    typedef logic [3:0]           month_t;
    typedef logic [4:0]           day_t;
    typedef logic [DAY_CNT_W-1:0] day_cnt_t;
    typedef logic [YR400_W-1:0]   yr400_t;
    typedef logic [QUOT_W-1:0]    quot_t;
    typedef logic [PC_W-1:0]      pc_t;

    // ceil(2^25 / 400): floor(y * RECIP >> 25) == floor(y / 400) for 16-bit y
    localparam logic [RECIP_W-1:0] RECIP = 17'd83887;

    localparam yr400_t YR_CYCLE   = 9'd400;
    localparam yr400_t YR_CENT    = 9'd100;
    localparam yr400_t YR_CENT2   = 9'd200;
    localparam yr400_t YR_CENT3   = 9'd300;
    localparam yr400_t YR_LAST    = 9'd399;

    localparam day_cnt_t RESET_DAY   = 17'd1;
    localparam month_t   RESET_MONTH = 4'd1;
    localparam int       RESET_YEAR_I = 2000;
    localparam year_t    RESET_YEAR  = YEAR_BITS'(RESET_YEAR_I);
    localparam yr400_t   RESET_YR400 = YR400_W'(RESET_YEAR_I % 400);

    // Command codes
    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_LOAD = 1'b1;

    localparam month_t MONTH_JAN = 4'd1;
    localparam month_t MONTH_FEB = 4'd2;
    localparam month_t MONTH_APR = 4'd4;
    localparam month_t MONTH_JUN = 4'd6;
    localparam month_t MONTH_SEP = 4'd9;
    localparam month_t MONTH_NOV = 4'd11;
    localparam month_t MONTH_DEC = 4'd12;

    localparam day_t LEN_28 = 5'd28;
    localparam day_t LEN_29 = 5'd29;
    localparam day_t LEN_30 = 5'd30;
    localparam day_t LEN_31 = 5'd31;

    typedef struct packed {
        logic                cmd;
        day_t                day_in;
        month_t              month_in;
        year_t               year_in;
        logic [ADD_W-1:0]    add_days;
    } req_t;

    typedef struct packed {
        day_t   day_out;
        month_t month_out;
        year_t  year_out;
    } rsp_t;

    // Datapath operation selected by the control word
    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_MOD,
        OP_ADD,
        OP_WALK,
        OP_EMIT
    } dp_op_t;

    // Jump condition; not taken falls through to the next step
    typedef enum logic [2:0] {
        JC_NEVER,
        JC_ALWAYS,
        JC_NO_REQ,
        JC_IS_ADD,
        JC_OVER,
        JC_OUT_BUSY
    } jcond_t;

    typedef struct packed {
        logic   in_rdy;
        dp_op_t op;
        jcond_t jc;
        pc_t    target;
    } ctrl_t;

    typedef struct packed {
        logic accept;
        logic is_add;
        logic over;
        logic out_busy;
    } seq_flags_t;

    // Program step addresses
    localparam pc_t PC_WAIT = 3'd0;
    localparam pc_t PC_DISP = 3'd1;
    localparam pc_t PC_LD0  = 3'd2;
    localparam pc_t PC_LD1  = 3'd3;
    localparam pc_t PC_ADD  = 3'd5;
    localparam pc_t PC_WALK = 3'd6;
    localparam pc_t PC_EMIT = 3'd7;

    // Microprogram; the step after PC_EMIT wraps to PC_WAIT
    function automatic ctrl_t rom_word(pc_t pc);
        ctrl_t w;
        w = '{in_rdy: 1'b0, op: OP_NONE, jc: JC_ALWAYS, target: PC_WAIT};
        unique case (pc)
            PC_WAIT: w = '{in_rdy: 1'b1, op: OP_NONE, jc: JC_NO_REQ,   target: PC_WAIT};
            PC_DISP: w = '{in_rdy: 1'b0, op: OP_NONE, jc: JC_IS_ADD,   target: PC_ADD};
            PC_LD0:  w = '{in_rdy: 1'b0, op: OP_LOAD, jc: JC_NEVER,    target: PC_WAIT};
            PC_LD1:  w = '{in_rdy: 1'b0, op: OP_MOD,  jc: JC_ALWAYS,   target: PC_EMIT};
            PC_ADD:  w = '{in_rdy: 1'b0, op: OP_ADD,  jc: JC_NEVER,    target: PC_WAIT};
            PC_WALK: w = '{in_rdy: 1'b0, op: OP_WALK, jc: JC_OVER,     target: PC_WALK};
            PC_EMIT: w = '{in_rdy: 1'b0, op: OP_EMIT, jc: JC_OUT_BUSY, target: PC_EMIT};
            default: w = '{in_rdy: 1'b0, op: OP_NONE, jc: JC_ALWAYS,   target: PC_WAIT};
        endcase
        return w;
    endfunction

    // Leap test from year mod 4 and year mod 400
    function automatic logic is_leap(logic [1:0] low, yr400_t r400);
        return (low == 2'd0) && (r400 != YR_CENT) && (r400 != YR_CENT2)
            && (r400 != YR_CENT3);
    endfunction

    // Month length; out-of-range months count as 31 days
    function automatic day_t month_len(month_t m, logic leap);
        day_t len;
        priority if (m == MONTH_FEB) begin
            len = leap ? LEN_29 : LEN_28;
        end else if (m == MONTH_APR || m == MONTH_JUN || m == MONTH_SEP
                     || m == MONTH_NOV) begin
            len = LEN_30;
        end else begin
            len = LEN_31;
        end
        return len;
    endfunction

endpackage

>>> rtl/gregorian_date_day_adder_unit.sv
// Gregorian date day adder.
// Request channel (req_valid / req_stall / req): cmd selects load (set the
// stored date from day_in, month_in, year_in) or add (add add_days to the
// stored date and carry whole months into month and year). Every request
// transaction produces exactly one response transaction on rsp_valid /
// rsp_stall / rsp carrying the resulting date.
// A load passes the dispatch, load, modulo and emit steps; an add passes
// dispatch, add, the month walk and emit, where the walk carries at most
// about 2150 months for add_days = 65535. One item is in flight at a time.
// The month walk retires one month per cycle through a single compare and
// subtract; a load spends one extra step forming year mod 400 with a
// reciprocal multiply.
// The response sits in an output register; while the receiver stalls it
// holds, and the sequencer waits at its emit step before taking the next
// request. A new request is taken as soon as the previous response has been
// written into that register.
// Reset brings the stored date to 1 January 2000 and the sequencer to its
// wait step; no response is pending after reset.
module gregorian_date_day_adder_unit
    import gdda_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

`include "gregorian_date_day_adder_unit_macros.svh"

    ctrl_t      ctrl;
    seq_flags_t flags;

    req_t     item_reg;
    day_cnt_t day_reg,   day_next;
    month_t   month_reg, month_next;
    year_t    year_reg,  year_next;
    yr400_t   yr400_reg, yr400_next;
    quot_t    q_reg,     q_next;
    rsp_t     rsp_reg;
    logic     rsp_valid_reg, rsp_valid_next;

    logic                          accept;
    logic                          leap;
    day_t                          len;
    logic                          over;
    logic                          out_busy;
    logic                          emit_fire;
    month_t                        month_inc;
    logic                          month_wrap;
    year_t                         year_inc;
    yr400_t                        yr400_inc;
    logic [YEAR_BITS+RECIP_W-1:0]  recip_prod;
    year_t                         q400;
    year_t                         rem_full;
    yr400_t                        rem400;

    // Sequencer
    gdda_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctrl  (ctrl)
    );

    // Handshakes
    assign req_stall = !ctrl.in_rdy;
    assign accept    = req_valid && !req_stall;
    assign out_busy  = rsp_valid_reg && rsp_stall;
    assign emit_fire = (ctrl.op == OP_EMIT) && !out_busy;

    // Month length of the stored date
    assign leap = is_leap(year_reg[1:0], yr400_reg);
    assign len  = month_len(month_reg, leap);
    assign over = day_reg > {{(DAY_CNT_W-5){1'b0}}, len};

    assign flags = '{accept:   accept,
                     is_add:   item_reg.cmd == CMD_ADD,
                     over:     over,
                     out_busy: out_busy};

    // Month and year step
    assign month_inc  = month_reg + 4'd1;
    assign month_wrap = (month_inc > MONTH_DEC) || (month_inc == 4'd0);
    assign year_inc   = year_reg + 1'b1;
    always_comb
    begin
        if (year_reg == '1 || yr400_reg == YR_LAST)
        begin
            yr400_inc = '0;
        end
        else
        begin
            yr400_inc = yr400_reg + 1'b1;
        end
    end

    // Year mod 400 from a reciprocal quotient
    assign recip_prod = {{RECIP_W{1'b0}}, item_reg.year_in}
                      * {{YEAR_BITS{1'b0}}, RECIP};
    assign q400       = {{(YEAR_BITS-QUOT_W){1'b0}}, q_reg}
                      * {{(YEAR_BITS-YR400_W){1'b0}}, YR_CYCLE};
    assign rem_full   = year_reg - q400;
    always_comb
    begin
        if (rem_full >= {{(YEAR_BITS-YR400_W){1'b0}}, YR_CYCLE})
        begin
            rem400 = YR400_W'(rem_full - {{(YEAR_BITS-YR400_W){1'b0}}, YR_CYCLE});
        end
        else
        begin
            rem400 = rem_full[YR400_W-1:0];
        end
    end

    // Datapath next state
    always_comb
    begin
        day_next   = day_reg;
        month_next = month_reg;
        year_next  = year_reg;
        yr400_next = yr400_reg;
        q_next     = q_reg;
        unique case (ctrl.op)
            OP_NONE: ;
            OP_EMIT: ;
            OP_LOAD:
            begin
                day_next   = {{(DAY_CNT_W-5){1'b0}}, item_reg.day_in};
                month_next = item_reg.month_in;
                year_next  = item_reg.year_in;
                q_next     = recip_prod[RECIP_SHIFT +: QUOT_W];
            end
            OP_MOD:
            begin
                yr400_next = rem400;
            end
            OP_ADD:
            begin
                day_next = DAY_CNT_W'(day_reg + {{(DAY_CNT_W-ADD_W){1'b0}},
                                                 item_reg.add_days});
            end
            OP_WALK:
            begin
                if (over)
                begin
                    day_next = day_reg - {{(DAY_CNT_W-5){1'b0}}, len};
                    if (month_wrap)
                    begin
                        month_next = MONTH_JAN;
                        year_next  = year_inc;
                        yr400_next = yr400_inc;
                    end
                    else
                    begin
                        month_next = month_inc;
                    end
                end
            end
            default: ;
        endcase
    end

    // Response slot
    always_comb
    begin
        priority if (emit_fire)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    // Hold date state and response valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            day_reg       <= RESET_DAY;
            month_reg     <= RESET_MONTH;
            year_reg      <= RESET_YEAR;
            yr400_reg     <= RESET_YR400;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            day_reg       <= day_next;
            month_reg     <= month_next;
            year_reg      <= year_next;
            yr400_reg     <= yr400_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Capture the request transaction, quotient and response payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= req;
        end
        q_reg <= q_next;
        if (emit_fire)
        begin
            rsp_reg <= '{day_out:   day_reg[4:0],
                         month_out: month_reg,
                         year_out:  year_reg};
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Checks
    `GDDA_CHECK_NEXT(a_walk_until_fit, (ctrl.op == OP_WALK) && over, ctrl.op == OP_WALK,
                     "month walk left while day still exceeds month length")
    `GDDA_CHECK_NEXT(a_walk_month_range, (ctrl.op == OP_WALK) && over,
                     (month_reg >= MONTH_JAN) && (month_reg <= MONTH_DEC),
                     "month step produced a month outside 1..12")
    `GDDA_CHECK_NOW(a_yr400_range, 1'b1, yr400_reg < YR_CYCLE,
                    "year mod 400 tracker out of range")

endmodule

>>> rtl/gdda_seq.sv
module gdda_seq
    import gdda_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  seq_flags_t flags,
    output ctrl_t      ctrl
);

    pc_t  pc_reg;
    pc_t  pc_next;
    logic taken;

    // Fetch the control word for the current step
    assign ctrl = rom_word(pc_reg);

    // Evaluate the jump condition
    always_comb
    begin
        unique case (ctrl.jc)
            JC_NEVER:    taken = 1'b0;
            JC_ALWAYS:   taken = 1'b1;
            JC_NO_REQ:   taken = !flags.accept;
            JC_IS_ADD:   taken = flags.is_add;
            JC_OVER:     taken = flags.over;
            JC_OUT_BUSY: taken = flags.out_busy;
            default:     taken = 1'b1;
        endcase
    end

    // Jump or advance
    assign pc_next = taken ? ctrl.target : pc_t'(pc_reg + 1'b1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= PC_WAIT;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

>>> tb/gregorian_date_day_adder_unit_tb.sv
`timescale 1ns / 100ps

module gregorian_date_day_adder_unit_tb;
    import gdda_pkg::*;

    // Months outside the calendar that the block still accepts on a load
    localparam month_t MONTH_ZERO = 4'd0;
    localparam month_t MONTH_13   = 4'd13;
    localparam month_t MONTH_TOP  = 4'd15;

    localparam int IDLE_LIMIT     = 20000;
    localparam int PRINT_LIMIT    = 100;
    localparam int RANDOM_ITEMS   = 240;
    localparam int PRESSURE_ITEMS = 12;
    localparam int HOLD_CYCLES    = 400;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    // Date held by the predictor
    logic [DAY_CNT_W-1:0] date_day = 17'd1;
    month_t               date_month = MONTH_JAN;
    year_t                date_year = 16'd2000;

    rsp_t expected_dates[$];
    int   mismatch_count = 0;
    int   burst_left = 0;
    int   hold_left = 0;
    int   idle_cycles = 0;

    gregorian_date_day_adder_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic bit leap_year(year_t y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int unsigned month_days(month_t m, year_t y);
        if (m == MONTH_FEB)
        begin
            return leap_year(y) ? 32'(LEN_29) : 32'(LEN_28);
        end
        if (m inside {MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV})
        begin
            return 32'(LEN_30);
        end
        return 32'(LEN_31);
    endfunction

    // Apply one transaction to the predicted date and return the date it reports
    function automatic rsp_t advance_date(req_t r);
        rsp_t        res;
        int unsigned len;
        if (r.cmd == CMD_LOAD)
        begin
            date_day   = DAY_CNT_W'(r.day_in);
            date_month = r.month_in;
            date_year  = r.year_in;
        end
        else
        begin
            date_day = date_day + DAY_CNT_W'(r.add_days);
            len = month_days(date_month, date_year);
            // Carry whole months while the day overruns the current one
            while (date_day > len)
            begin
                date_day   = date_day - DAY_CNT_W'(len);
                date_month = date_month + 4'd1;
                if (date_month > MONTH_DEC || date_month == MONTH_ZERO)
                begin
                    date_month = MONTH_JAN;
                    date_year  = date_year + 1'b1;
                end
                len = month_days(date_month, date_year);
            end
        end
        res.day_out   = date_day[4:0];
        res.month_out = date_month;
        res.year_out  = date_year;
        return res;
    endfunction

    // Unused fields carry random junk so they are seen to be ignored
    function automatic req_t random_fields();
        logic [63:0] bits;
        bits = {$urandom, $urandom};
        return bits[$bits(req_t)-1:0];
    endfunction

    function automatic req_t make_load(day_t d, month_t m, year_t y);
        req_t r;
        r = random_fields();
        r.cmd      = CMD_LOAD;
        r.day_in   = d;
        r.month_in = m;
        r.year_in  = y;
        return r;
    endfunction

    function automatic req_t make_add(logic [ADD_W-1:0] n);
        req_t r;
        r = random_fields();
        r.cmd      = CMD_ADD;
        r.add_days = n;
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        mismatch_count++;
        // Keep the log short when something is badly broken
        if (mismatch_count <= PRINT_LIMIT)
        begin
            $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
        end
    endtask

    // Offer one transaction, hold it until taken, then record its expected date
    task automatic offer_request(req_t item);
        req       <= item;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
        begin
            @(posedge clk);
        end
        expected_dates.push_back(advance_date(item));
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30)
                                                     : $urandom_range(0, 5);
        end
    endtask

    // Check each response transaction against the oldest expected date
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_dates.size() == 0)
            begin
                report_mismatch("response with none expected", longint'(rsp), 0);
            end
            else
            begin
                want = expected_dates.pop_front();
                if (rsp.day_out !== want.day_out)
                begin
                    report_mismatch("day_out", longint'(rsp.day_out),
                                    longint'(want.day_out));
                end
                if (rsp.month_out !== want.month_out)
                begin
                    report_mismatch("month_out", longint'(rsp.month_out),
                                    longint'(want.month_out));
                end
                if (rsp.year_out !== want.year_out)
                begin
                    report_mismatch("year_out", longint'(rsp.year_out),
                                    longint'(want.year_out));
                end
            end
        end
    end

    // Receiver stall pattern: random-length phases of no, light or heavy stall,
    // overridden by a long hold-off when one is requested
    int mode_left = 0;
    int stall_pct = 0;
    always @(posedge clk)
    begin
        logic stall_next;
        if (hold_left > 0)
        begin
            hold_left--;
            stall_next = 1'b1;
        end
        else
        begin
            if (mode_left == 0)
            begin
                mode_left = $urandom_range(20, 150);
                case ($urandom_range(0, 2))
                    0: stall_pct = 0;
                    1: stall_pct = 25;
                    default: stall_pct = 60;
                endcase
            end
            mode_left--;
            stall_next = ($urandom_range(0, 99) < stall_pct);
        end
        rsp_stall <= stall_next;
    end

    // Watchdog: end the run when no transaction moves for too long
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // Stepping from the reset date, through a leap February
    task automatic test_reset_date();
        offer_request(make_add(16'd0));
        offer_request(make_add(16'd31));
        offer_request(make_add(16'd29));
    endtask

    // Unchecked loads: year wrap, day zero, months outside 1..12, oversized day
    task automatic test_load_extremes();
        offer_request(make_load(5'd31, MONTH_DEC, 16'hFFFF));
        offer_request(make_add(16'd1));
        offer_request(make_load(5'd0, MONTH_ZERO, 16'd0));
        offer_request(make_add(16'd0));
        offer_request(make_load(5'd31, MONTH_TOP, 16'd0));
        offer_request(make_add(16'd1));
        offer_request(make_load(5'd31, MONTH_ZERO, 16'd5));
        offer_request(make_add(16'd1));
        offer_request(make_load(5'd31, MONTH_13, 16'd7));
        offer_request(make_add(16'd0));
        offer_request(make_load(5'd31, MONTH_APR, 16'd2001));
        offer_request(make_add(16'd0));
    endtask

    // Leap rule: century, 400-year, year zero and a plain year
    task automatic test_leap_rules();
        offer_request(make_load(5'd28, MONTH_FEB, 16'd1900));
        offer_request(make_add(16'd1));
        offer_request(make_load(5'd28, MONTH_FEB, 16'd2000));
        offer_request(make_add(16'd1));
        offer_request(make_load(5'd28, MONTH_FEB, 16'd0));
        offer_request(make_add(16'd1));
        offer_request(make_load(5'd28, MONTH_FEB, 16'd2023));
        offer_request(make_add(16'd1));
    endtask

    task automatic test_long_adds();
        offer_request(make_add(16'hFFFF));
        offer_request(make_add(16'hFFFF));
    endtask

    function automatic req_t random_item();
        req_t        r;
        month_t      m;
        year_t       y;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 5)
        begin
            // Noise: any field pattern at all
            r = random_fields();
        end
        else if (pick < 20)
        begin
            m = month_t'($urandom_range(1, 12));
            case ($urandom_range(0, 3))
                0: y = year_t'($urandom_range(0, 65535));
                1: y = year_t'(100 * $urandom_range(0, 655) - $urandom_range(0, 1));
                2: y = year_t'($urandom_range(1890, 2410));
                default: y = year_t'($urandom_range(65530, 65535));
            endcase
            if ($urandom_range(0, 2) == 0)
            begin
                r = make_load(day_t'(month_days(m, y)), m, y);
            end
            else
            begin
                r = make_load(day_t'($urandom_range(1, month_days(m, y))), m, y);
            end
        end
        else
        begin
            // Mostly short adds; a few reach the full day count
            case ($urandom_range(0, 49))
                0, 1, 2, 3:              r = make_add(16'($urandom));
                4, 5, 6, 7, 8, 9:        r = make_add(16'($urandom_range(0, 4095)));
                10, 11, 12, 13, 14, 15,
                16, 17, 18, 19, 20, 21,
                22, 23, 24:              r = make_add(16'($urandom_range(0, 400)));
                default:                 r = make_add(16'($urandom_range(0, 40)));
            endcase
        end
        return r;
    endfunction

    // Long receiver hold-off while the sender keeps offering back to back
    task automatic test_backpressure();
        hold_left  = HOLD_CYCLES;
        burst_left = PRESSURE_ITEMS;
        repeat (PRESSURE_ITEMS)
        begin
            offer_request(make_add(16'($urandom_range(0, 100))));
        end
    endtask

    task automatic test_random_traffic();
        repeat (RANDOM_ITEMS)
        begin
            offer_request(random_item());
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_date();
        test_load_extremes();
        test_leap_rules();
        test_long_adds();
        test_backpressure();
        test_random_traffic();

        // Drop valid, drain outstanding dates, then let the block settle
        req_valid <= 1'b0;
        while (expected_dates.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);

        if (mismatch_count == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
